/* rtl/core/rtm_pkg.sv */
package rtm_pkg;

    localparam int TABLE_DEPTH = 256;   // power of two: home bucket is the low hash bits
    localparam int MAX_ARITY   = 4;
    localparam int VALUE_BITS  = 12;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int ARITY_BITS  = 3;
    localparam int FIELD_BITS  = 12;

    localparam logic [31:0] HASH_SEED = 32'h5509_44F8;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic CFG_SUPPORTS = 1'b0;
    localparam logic CFG_ARITY    = 1'b1;

    typedef struct packed {
        logic [1:0]            action;
        logic [FIELD_BITS-1:0] value0;
        logic [FIELD_BITS-1:0] value1;
        logic [FIELD_BITS-1:0] value2;
        logic [FIELD_BITS-1:0] value3;
    } in_word_t;

    typedef struct packed {
        logic supported;
        logic status;
    } out_word_t;

    typedef logic [MAX_ARITY-1:0][VALUE_BITS-1:0] key_t;

    typedef struct packed {
        logic used;
        key_t vals;
    } entry_t;

    typedef struct packed {
        logic                 clear;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        entry_t               wr_entry;
    } tbl_req_t;

    typedef struct packed {
        logic   ne;
        entry_t entry;
    } tbl_rsp_t;

endpackage

/* rtl/core/rtm_table.sv */
module rtm_table (
    input  logic              clk,
    input  logic              rst_n,
    input  rtm_pkg::tbl_req_t req,
    output rtm_pkg::tbl_rsp_t rsp
);
    import rtm_pkg::*;

    // ne_reg marks a slot as used or tombstone; a clear slot reads as empty
    logic [TABLE_DEPTH-1:0] ne_reg;
    logic                   rd_ne_reg;
    entry_t                 mem [TABLE_DEPTH];
    entry_t                 rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg    <= '0;
            rd_ne_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                ne_reg <= '0;
            end
            else if (req.wr_en)
            begin
                ne_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_ne_reg <= ne_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_entry_reg <= mem[req.rd_addr];
        end
    end

    assign rsp.ne    = rd_ne_reg;
    assign rsp.entry = rd_entry_reg;

endmodule

/* rtl/core/relation_tuple_membership_unit.sv */
// Hashed tuple set: query, add conflicting, load and clear, one word per command.
// The probe reads P slots in turn from the home bucket, P being 1 to 256, one a cycle
// from the synchronous table; done is registered after the last. A clear reports
// done the cycle after its accept. Busy is high while probing; commands wait for idle.
// Reset: asynchronous; every slot reads empty at once, supports = 1, arity = 2.
// Results are strobed for one cycle on done; the receiver cannot stall.
module relation_tuple_membership_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rtm_pkg::in_word_t            cmd,
    output logic                         done,
    output rtm_pkg::out_word_t           result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [rtm_pkg::ARITY_BITS-1:0] cfg_data
);
    import rtm_pkg::*;

    typedef enum logic {S_IDLE, S_PROBE} state_t;

    state_t                state_reg, state_next;
    logic                  supports_reg;
    logic [ARITY_BITS-1:0] arity_reg;
    logic [1:0]            action_reg, action_next;
    key_t                  key_reg, key_next;
    logic [ARITY_BITS-1:0] n_reg, n_next;
    logic [ADDR_BITS-1:0]  pos_reg, pos_next;
    logic [ADDR_BITS-1:0]  probe_reg, probe_next;
    logic                  free_valid_reg, free_valid_next;
    logic [ADDR_BITS-1:0]  free_reg, free_next;
    logic                  done_reg, done_next;
    out_word_t             result_reg, result_next;

    tbl_req_t              req;
    tbl_rsp_t              rsp;

    logic [ARITY_BITS-1:0] n_eff;
    key_t                  key_in;
    logic [31:0]           hash_in;
    logic                  accept;
    logic                  match, hit, empty, tomb, last, finish;
    logic                  free_now_valid;
    logic [ADDR_BITS-1:0]  free_now;
    logic                  is_insert, is_erase;
    entry_t                new_entry;

    function automatic logic [31:0] tuple_hash(key_t v, logic [ARITY_BITS-1:0] n);
        logic [31:0] h;
        h = {{(32-ARITY_BITS){1'b0}}, n} ^ HASH_SEED;
        for (int i = 0; i < MAX_ARITY; i++)
        begin
            if (i < int'(n))
            begin
                h = h ^ (({{(32-VALUE_BITS){1'b0}}, v[i]} << (3*i)) ^ (h >> (3*i)));
            end
        end
        return h;
    endfunction

    rtm_table u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always_comb
    begin
        if (arity_reg == '0)
            n_eff = ARITY_BITS'(1);
        else if (arity_reg > ARITY_BITS'(MAX_ARITY))
            n_eff = ARITY_BITS'(MAX_ARITY);
        else
            n_eff = arity_reg;
    end

    assign key_in[0] = cmd.value0[VALUE_BITS-1:0];
    assign key_in[1] = cmd.value1[VALUE_BITS-1:0];
    assign key_in[2] = cmd.value2[VALUE_BITS-1:0];
    assign key_in[3] = cmd.value3[VALUE_BITS-1:0];
    assign hash_in   = tuple_hash(key_in, n_eff);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // compare only the values in use
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_ARITY; i++)
        begin
            if (i < int'(n_reg) && rsp.entry.vals[i] != key_reg[i])
                match = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ARITY; i++)
        begin
            new_entry.vals[i] = (i < int'(n_reg)) ? key_reg[i] : '0;
        end
        new_entry.used = 1'b1;
    end

    assign empty          = !rsp.ne;
    assign hit            = rsp.ne && rsp.entry.used && match;
    assign tomb           = rsp.ne && !rsp.entry.used;
    assign last           = (probe_reg == ADDR_BITS'(TABLE_DEPTH - 1));
    assign finish         = empty || hit || last;
    assign free_now_valid = free_valid_reg || empty || tomb;
    assign free_now       = free_valid_reg ? free_reg : pos_reg;
    assign is_erase       = (action_reg == ACT_ADD) && supports_reg;
    assign is_insert      = (action_reg == ACT_LOAD) || ((action_reg == ACT_ADD) && !supports_reg);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        free_valid_next = free_valid_reg;
        free_next       = free_reg;
        done_next       = 1'b0;
        result_next     = '0;

        req.clear       = 1'b0;
        req.rd_en       = 1'b0;
        req.rd_addr     = pos_reg + ADDR_BITS'(1);
        req.wr_en       = 1'b0;
        req.wr_addr     = free_now;
        req.wr_entry    = new_entry;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_CLEAR)
                    begin
                        req.clear = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        req.rd_en       = 1'b1;
                        req.rd_addr     = hash_in[ADDR_BITS-1:0];
                        pos_next        = hash_in[ADDR_BITS-1:0];
                        probe_next      = '0;
                        free_valid_next = 1'b0;
                        action_next     = cmd.action;
                        key_next        = key_in;
                        n_next          = n_eff;
                        state_next      = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (finish)
                begin
                    // write back the tombstone or the new entry, then report
                    if (is_erase)
                    begin
                        req.wr_en          = hit;
                        req.wr_addr        = pos_reg;
                        req.wr_entry.used  = 1'b0;
                    end
                    else if (is_insert)
                    begin
                        req.wr_en = !hit && free_now_valid;
                    end
                    result_next.supported = (action_reg == ACT_QUERY) && (hit == supports_reg);
                    result_next.status    = is_insert && !hit && !free_now_valid;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    // advance to the next slot, remember the first tombstone
                    req.rd_en       = 1'b1;
                    pos_next        = pos_reg + ADDR_BITS'(1);
                    probe_next      = probe_reg + ADDR_BITS'(1);
                    free_valid_next = free_now_valid;
                    free_next       = free_now;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            supports_reg   <= 1'b1;
            arity_reg      <= ARITY_BITS'(2);
            free_valid_reg <= 1'b0;
            probe_reg      <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_valid_reg <= free_valid_next;
            probe_reg      <= probe_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SUPPORTS: supports_reg <= cfg_data[0];
                    CFG_ARITY:    arity_reg    <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        n_reg      <= n_next;
        pos_reg    <= pos_next;
        free_reg   <= free_next;
    end

endmodule

/* test/rtm_checker.sv */
module rtm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  rtm_pkg::in_word_t              cmd,
    input  logic                           done,
    input  rtm_pkg::out_word_t             result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [rtm_pkg::ARITY_BITS-1:0] cfg_data,
    output int                             outstanding,
    output int                             mismatches
);
    import rtm_pkg::*;

    typedef enum logic [1:0] {SLOT_EMPTY, SLOT_USED, SLOT_TOMB} slot_tag_t;

    slot_tag_t             slot_tag [TABLE_DEPTH];
    key_t                  slot_key [TABLE_DEPTH];
    logic                  supports_cfg;
    logic [ARITY_BITS-1:0] arity_cfg;
    out_word_t             expected_results [$];
    int                    fail_count;

    function automatic int unsigned active_arity();
        if (arity_cfg == 0)
            return 1;
        if (arity_cfg > MAX_ARITY)
            return MAX_ARITY;
        return 32'(arity_cfg);
    endfunction

    function automatic logic [31:0] tuple_hash(key_t k, int unsigned n);
        logic [31:0] h;
        h = 32'(n) ^ HASH_SEED;
        for (int i = 0; i < n; i++)
            h = h ^ ((32'(k[i]) << (3 * i)) ^ (h >> (3 * i)));
        return h;
    endfunction

    function automatic bit same_tuple(int slot, key_t k, int unsigned n);
        for (int i = 0; i < n; i++)
            if (slot_key[slot][i] != k[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Walk from the home bucket; free_at gets the first tombstone or empty slot seen.
    function automatic int find_tuple(key_t k, int unsigned n, output int free_at);
        int pos;
        pos = int'(tuple_hash(k, n) % 32'(TABLE_DEPTH));
        free_at = -1;
        for (int step = 0; step < TABLE_DEPTH; step++)
        begin
            if (slot_tag[pos] == SLOT_EMPTY)
            begin
                if (free_at < 0)
                    free_at = pos;
                return -1;
            end
            if (slot_tag[pos] == SLOT_USED)
            begin
                if (same_tuple(pos, k, n))
                    return pos;
            end
            else if (free_at < 0)
            begin
                free_at = pos;
            end
            pos = (pos + 1) % TABLE_DEPTH;
        end
        return -1;
    endfunction

    // Returns the dropped flag.
    function automatic logic store_tuple(key_t k, int unsigned n);
        int hit;
        int free_at;
        hit = find_tuple(k, n, free_at);
        if (hit >= 0)
            return 1'b0;
        if (free_at < 0)
            return 1'b1;
        slot_tag[free_at] = SLOT_USED;
        slot_key[free_at] = '0;
        for (int i = 0; i < n; i++)
            slot_key[free_at][i] = k[i];
        return 1'b0;
    endfunction

    function automatic out_word_t membership_response(in_word_t w);
        out_word_t   r;
        key_t        k;
        int unsigned n;
        int          hit;
        int          free_at;
        r = '0;
        n = active_arity();
        k[0] = w.value0[VALUE_BITS-1:0];
        k[1] = w.value1[VALUE_BITS-1:0];
        k[2] = w.value2[VALUE_BITS-1:0];
        k[3] = w.value3[VALUE_BITS-1:0];
        case (w.action)
            ACT_QUERY:
            begin
                hit = find_tuple(k, n, free_at);
                r.supported = ((hit >= 0) == supports_cfg);
            end
            ACT_ADD:
            begin
                if (supports_cfg)
                begin
                    hit = find_tuple(k, n, free_at);
                    if (hit >= 0)
                        slot_tag[hit] = SLOT_TOMB;
                end
                else
                begin
                    r.status = store_tuple(k, n);
                end
            end
            ACT_LOAD:
            begin
                r.status = store_tuple(k, n);
            end
            default:
            begin
                for (int s = 0; s < TABLE_DEPTH; s++)
                    slot_tag[s] = SLOT_EMPTY;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_DEPTH; s++)
            begin
                slot_tag[s] = SLOT_EMPTY;
                slot_key[s] = '0;
            end
            supports_cfg = 1'b1;
            arity_cfg    = 3'd2;
            expected_results.delete();
            fail_count   = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word: supported=%0b status=%0b",
                                 $time, result.supported, result.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.supported !== want.supported || result.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result mismatch: expected supported=%0b status=%0b,",
                                      " got supported=%0b status=%0b"}, $time,
                                     want.supported, want.status,
                                     result.supported, result.status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SUPPORTS)
                    supports_cfg = cfg_data[0];
                else
                    arity_cfg = cfg_data;
            end
            // queue the expected word behind any still pending
            if (start && !busy)
                expected_results.insert(expected_results.size(), membership_response(cmd));
            outstanding <= expected_results.size();
            mismatches  <= fail_count;
        end
    end

endmodule

/* test/tb_top.sv */
module tb_top;
    import rtm_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_word_t              cmd;
    logic                  done;
    out_word_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [ARITY_BITS-1:0] cfg_data;
    int                    outstanding;
    int                    mismatches;

    key_t                  recent_keys [16];
    int                    recent_count = 0;
    int                    recent_head  = 0;
    int                    burst_left   = 0;
    logic [ARITY_BITS-1:0] arity_now    = 3'd2;

    logic [2:0] phase_supports [12] = '{1, 0, 1, 0, 1, 0, 3, 2, 1, 0, 1, 0};
    logic [2:0] phase_arity    [12] = '{2, 1, 4, 3, 1, 4, 2, 0, 7, 5, 3, 2};

    relation_tuple_membership_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic in_word_t make_word(logic [1:0] action, int v0, int v1, int v2, int v3);
        in_word_t w;
        w.action = action;
        w.value0 = FIELD_BITS'(v0);
        w.value1 = FIELD_BITS'(v1);
        w.value2 = FIELD_BITS'(v2);
        w.value3 = FIELD_BITS'(v3);
        return w;
    endfunction

    // Half the tuples come back from a short history so that hits and erases land.
    function automatic in_word_t random_word();
        in_word_t w;
        key_t     k;
        int       roll;
        int       pick;
        int       used;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            w.action = ACT_CLEAR;
        else if (roll < 45)
            w.action = ACT_QUERY;
        else if (roll < 70)
            w.action = ACT_ADD;
        else
            w.action = ACT_LOAD;
        if (recent_count > 0 && $urandom_range(0, 1) == 1) begin
            k = recent_keys[$urandom_range(0, recent_count - 1)];
            used = (arity_now == 0) ? 1 : (arity_now > MAX_ARITY) ? MAX_ARITY : arity_now;
            // scramble the ignored tail
            if ($urandom_range(0, 1) == 1)
                for (int i = used; i < MAX_ARITY; i++)
                    k[i] = VALUE_BITS'($urandom);
        end
        else begin
            for (int i = 0; i < MAX_ARITY; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    k[i] = VALUE_BITS'($urandom_range(0, 3));
                else if (pick < 8)
                    k[i] = VALUE_BITS'($urandom);
                else
                    k[i] = (pick == 8) ? '0 : '1;
            end
            recent_keys[recent_head] = k;
            recent_head = (recent_head + 1) % 16;
            if (recent_count < 16)
                recent_count++;
        end
        w.value0 = FIELD_BITS'(k[0]);
        w.value1 = FIELD_BITS'(k[1]);
        w.value2 = FIELD_BITS'(k[2]);
        w.value3 = FIELD_BITS'(k[3]);
        return w;
    endfunction

    // Hold start across a burst; drop it only for a gap.
    task automatic send(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_relation(input logic [2:0] supports_data, input logic [2:0] arity_data);
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SUPPORTS;
        cfg_data  <= supports_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_ARITY;
        cfg_data  <= arity_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        arity_now = arity_data;
    endtask

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int ofs;
        int spare;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SUPPORTS;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: stored tuples support, arity 2
        send(make_word(ACT_QUERY, 0, 0, 0, 0));
        send(make_word(ACT_LOAD, 0, 0, 0, 0));
        send(make_word(ACT_QUERY, 0, 0, 0, 0));
        send(make_word(ACT_LOAD, 0, 0, 7, 9));
        send(make_word(ACT_QUERY, 0, 0, 4095, 4095));
        send(make_word(ACT_LOAD, 4095, 4095, 4095, 4095));
        send(make_word(ACT_QUERY, 4095, 4095, 0, 0));
        send(make_word(ACT_ADD, 0, 0, 0, 0));
        send(make_word(ACT_QUERY, 0, 0, 0, 0));
        send(make_word(ACT_ADD, 0, 0, 0, 0));
        send(make_word(ACT_LOAD, 0, 0, 0, 0));
        send(make_word(ACT_QUERY, 0, 0, 0, 0));
        send(make_word(ACT_QUERY, 1, 0, 0, 0));
        send(make_word(ACT_CLEAR, 4095, 4095, 4095, 4095));
        send(make_word(ACT_QUERY, 4095, 4095, 4095, 4095));

        set_relation(3'd0, 3'd4);
        send(make_word(ACT_QUERY, 1, 2, 3, 4));
        send(make_word(ACT_ADD, 1, 2, 3, 4));
        send(make_word(ACT_QUERY, 1, 2, 3, 4));
        send(make_word(ACT_ADD, 1, 2, 3, 4));
        send(make_word(ACT_LOAD, 4095, 0, 4095, 0));
        send(make_word(ACT_QUERY, 4095, 0, 4095, 0));

        // shrink arity over a non-empty set
        set_relation(3'd1, 3'd1);
        send(make_word(ACT_QUERY, 1, 9, 9, 9));
        send(make_word(ACT_QUERY, 4095, 0, 0, 0));
        send(make_word(ACT_CLEAR, 0, 0, 0, 0));

        // fill every slot with distinct one-value tuples
        ofs   = $urandom_range(0, 15);
        spare = (ofs + 1) % 16;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send(make_word(ACT_LOAD, (i << 4) | ofs, $urandom, $urandom, $urandom));
        repeat (6)
            send(make_word(ACT_LOAD, ($urandom_range(0, 255) << 4) | spare, 0, 0, 0));
        send(make_word(ACT_LOAD, ($urandom_range(0, 255) << 4) | ofs, 0, 0, 0));
        send(make_word(ACT_QUERY, ($urandom_range(0, 255) << 4) | ofs, 0, 0, 0));
        send(make_word(ACT_QUERY, ($urandom_range(0, 255) << 4) | spare, 0, 0, 0));
        set_relation(3'd0, 3'd1);
        send(make_word(ACT_ADD, ($urandom_range(0, 255) << 4) | spare, 0, 0, 0));
        send(make_word(ACT_QUERY, ($urandom_range(0, 255) << 4) | ofs, 0, 0, 0));
        send(make_word(ACT_QUERY, ($urandom_range(0, 255) << 4) | spare, 0, 0, 0));
        set_relation(3'd1, 3'd1);
        for (int i = 0; i < 4; i++)
            send(make_word(ACT_ADD, ((i * 37) << 4) | ofs, 0, 0, 0));
        for (int i = 0; i < 5; i++)
            send(make_word(ACT_LOAD, ((i * 37) << 4) | spare, 0, 0, 0));
        for (int i = 0; i < 5; i++)
            send(make_word(ACT_QUERY, ((i * 37) << 4) | ofs, 0, 0, 0));
        send(make_word(ACT_CLEAR, 0, 0, 0, 0));

        for (int p = 0; p < 12; p++) begin
            set_relation(phase_supports[p], phase_arity[p]);
            repeat (135)
                send(random_word());
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
